/* sv/rrq_pkg.sv */
// Shared types, sizes and codes for the round-robin thread run queue.
package rrq_pkg;

  localparam int MAX_THREADS = 16;
  localparam int ID_BITS     = 16;
  localparam int PORT_ID_W   = 16;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);

  // Result status codes.
  localparam logic [1:0] RES_DONE = 2'd0;
  localparam logic [1:0] RES_FULL = 2'd1;
  localparam logic [1:0] RES_NONE = 2'd2;

  // Thread state codes with a meaning of their own.
  localparam logic [2:0] TS_READY = 3'd0;
  localparam logic [2:0] TS_EXEC  = 3'd1;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_PICK   = 3'd2,
    ACT_YIELD  = 3'd3,
    ACT_MOVE   = 3'd4,
    ACT_LOOKUP = 3'd5,
    ACT_SET    = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT
  } fsm_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [2:0]         st;
  } entry_t;

  // Bring a port id down (or up) to the stored id width.
  function automatic logic [ID_BITS-1:0] to_id(input logic [PORT_ID_W-1:0] t);
    logic [63:0] w;
    w = '0;
    w[PORT_ID_W-1:0] = t;
    return w[ID_BITS-1:0];
  endfunction

  // Bring a stored id out to the port width.
  function automatic logic [PORT_ID_W-1:0] to_port(input logic [ID_BITS-1:0] t);
    logic [63:0] w;
    w = '0;
    w[ID_BITS-1:0] = t;
    return w[PORT_ID_W-1:0];
  endfunction

endpackage

/* sv/rrq_mem.sv */
// Queue entry store: one write port, one registered read port.
module rrq_mem
  import rrq_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [MAX_THREADS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/round_robin_thread_run_queue.sv */
// Top level of the round-robin thread run queue: sequencer around the entry store.
//
//  channel  | ports                                      | beat taken when
//  ---------+--------------------------------------------+-------------------------
//  command  | start, busy, action, thread_key, new_state | start & !busy at clk edge
//  result   | done, status, result_id, result_state      | done high, one cycle only
//
// Push, the unused action code and any search on an empty queue answer from idle:
// done rises on the cycle after the beat. Searching actions read the store one
// entry a cycle through its single read port; each entry read back is tested
// for a match and done is registered from that test. Delete, pick, yield and
// move-to-tail then shift the rest up by one entry a cycle; pick, yield and
// move-to-tail then write the held entry at the tail, while delete drops the
// count. Done is set as the tail is written or the count drops.
// Reset (rst, synchronous) empties the queue at once; no clearing pass.
// The receiver cannot stall; busy holds the next command off while working.
module round_robin_thread_run_queue
  import rrq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           action,
  input  logic [PORT_ID_W-1:0] thread_key,
  input  logic [2:0]           new_state,
  output logic                 done,
  output logic [1:0]           status,
  output logic [PORT_ID_W-1:0] result_id,
  output logic [2:0]           result_state
);

  // Control state.
  fsm_t             state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;     // valid entries
  logic [CNT_W-1:0] s, s_next;         // next entry index to read
  logic [CNT_W-1:0] didx, didx_next;   // index of the entry now on rdata
  logic             rv, rv_next;       // rdata holds a live read
  logic             done_next;

  // Payload registers.
  action_t            act, act_next;
  logic [ID_BITS-1:0] id_r, id_next;
  logic [2:0]         nst, nst_next;
  entry_t             sav, sav_next;    // entry on its way to the tail
  logic [1:0]           status_next;
  logic [PORT_ID_W-1:0] result_id_next;
  logic [2:0]           result_state_next;

  // Store port.
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  entry_t           rdata;

  // Shared decode.
  action_t          act_in;
  logic             accept;
  logic             issue;
  logic             hit;
  logic             search_in;
  logic             moves;
  logic [CNT_W-1:0] didx_m1;
  logic [CNT_W-1:0] cnt_m1;

  rrq_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (s[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign act_in  = action_t'(action);
  assign didx_m1 = didx - 1'b1;
  assign cnt_m1  = cnt - 1'b1;

  // Issue a read while a scan still has entries ahead of it.
  assign issue = (state != S_IDLE) && (s < cnt);

  assign search_in = (act_in == ACT_DELETE) || (act_in == ACT_PICK) ||
                     (act_in == ACT_YIELD)  || (act_in == ACT_MOVE) ||
                     (act_in == ACT_LOOKUP) || (act_in == ACT_SET);

  // Actions that take the matched entry out of its place.
  assign moves = (act == ACT_DELETE) || (act == ACT_PICK) ||
                 (act == ACT_YIELD)  || (act == ACT_MOVE);

  // Match test on the entry now read back: by state for pick and yield,
  // by id for all else.
  always_comb begin
    hit = 1'b0;
    if (state == S_SEARCH && rv) begin
      case (act)
        ACT_PICK:  hit = (rdata.st == TS_READY);
        ACT_YIELD: hit = (rdata.st == TS_EXEC);
        default:   hit = (rdata.id == id_r);
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && search_in && cnt != '0) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_next = moves ? S_SHIFT : S_IDLE;
        end else if (!rv && !issue) begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (!rv && !issue) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath, store port and result.
  always_comb begin
    cnt_next          = cnt;
    s_next            = s;
    didx_next         = didx;
    rv_next           = issue;
    act_next          = act;
    id_next           = id_r;
    nst_next          = nst;
    sav_next          = sav;
    done_next         = 1'b0;
    status_next       = status;
    result_id_next    = result_id;
    result_state_next = result_state;
    we                = 1'b0;
    waddr             = cnt[IDX_W-1:0];
    wdata             = sav;

    // Advance the read pointer with each read.
    if (issue) begin
      s_next    = s + 1'b1;
      didx_next = s;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          act_next = act_in;
          id_next  = to_id(thread_key);
          nst_next = new_state;
          s_next   = '0;
          result_id_next    = '0;
          result_state_next = '0;
          if (act_in == ACT_PUSH) begin
            done_next = 1'b1;
            if (cnt == CNT_W'(MAX_THREADS)) begin
              status_next = RES_FULL;
            end else begin
              // Append at the tail.
              we          = 1'b1;
              waddr       = cnt[IDX_W-1:0];
              wdata.id    = to_id(thread_key);
              wdata.st    = new_state;
              cnt_next    = cnt + 1'b1;
              status_next = RES_DONE;
            end
          end else if (!search_in || cnt == '0) begin
            done_next   = 1'b1;
            status_next = RES_NONE;
          end
        end
      end

      S_SEARCH: begin
        if (hit) begin
          case (act)
            ACT_LOOKUP: begin
              done_next         = 1'b1;
              status_next       = RES_DONE;
              result_id_next    = to_port(rdata.id);
              result_state_next = rdata.st;
            end
            ACT_SET: begin
              we                = 1'b1;
              waddr             = didx[IDX_W-1:0];
              wdata.id          = rdata.id;
              wdata.st          = nst;
              done_next         = 1'b1;
              status_next       = RES_DONE;
              result_id_next    = '0;
              result_state_next = '0;
            end
            default: begin
              // Hold the entry and restart the read just past it; drop the
              // read already in flight.
              sav_next.id = rdata.id;
              sav_next.st = (act == ACT_YIELD) ? TS_READY : rdata.st;
              s_next      = didx + 1'b1;
              rv_next     = 1'b0;
            end
          endcase
        end else if (!rv && !issue) begin
          done_next         = 1'b1;
          status_next       = RES_NONE;
          result_id_next    = '0;
          result_state_next = '0;
        end
      end

      S_SHIFT: begin
        if (rv) begin
          // Close the gap: each entry moves one place towards the head.
          we    = 1'b1;
          waddr = didx_m1[IDX_W-1:0];
          wdata = rdata;
        end else if (!issue) begin
          done_next         = 1'b1;
          status_next       = RES_DONE;
          result_state_next = '0;
          result_id_next    = (act == ACT_PICK) ? to_port(sav.id) : '0;
          if (act == ACT_DELETE) begin
            cnt_next = cnt_m1;
          end else begin
            we    = 1'b1;
            waddr = cnt_m1[IDX_W-1:0];
            wdata = sav;
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      s     <= '0;
      didx  <= '0;
      rv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      s     <= s_next;
      didx  <= didx_next;
      rv    <= rv_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    act          <= act_next;
    id_r         <= id_next;
    nst          <= nst_next;
    sav          <= sav_next;
    status       <= status_next;
    result_id    <= result_id_next;
    result_state <= result_state_next;
  end

endmodule
